// ----- rtl/tun_pkg.sv -----
// Package for the triangle unit normal pipeline: widths, sideband types and the
// iteration steps of the square root and reciprocal units.
// No dependencies.
package tun_pkg;

  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned NUM_COORDS    = 9;
  localparam int unsigned DIFF_BITS     = COORD_BITS + 1;
  localparam int unsigned PROD_BITS     = 2 * DIFF_BITS;
  localparam int unsigned CROSS_BITS    = PROD_BITS + 1;
  localparam int unsigned BLEN_BITS     = 6;
  localparam int unsigned MANT_BITS     = 30;
  localparam int unsigned SQR_BITS      = 2 * MANT_BITS;
  localparam int unsigned SUM_BITS      = SQR_BITS + 2;
  localparam int unsigned WORD_BITS     = 64;
  localparam int unsigned LEN_BITS      = 32;
  localparam int unsigned RSQ_BITS      = 60;
  localparam int unsigned OUT_FRAC_BITS = 14;
  localparam int unsigned NORMAL_WIDTH  = 16;
  localparam int unsigned NPROD_BITS    = MANT_BITS + LEN_BITS;
  localparam int unsigned RND_SHIFT     = RSQ_BITS - OUT_FRAC_BITS;
  localparam int unsigned NRM_BITS      = NPROD_BITS + 1 - RND_SHIFT;
  localparam int unsigned SQ_STAGES     = 16;
  localparam int unsigned DV_STAGES     = 16;
  localparam int unsigned IN_DATA_BITS  = NUM_COORDS * COORD_BITS;
  localparam int unsigned OUT_DATA_BITS = 3 * NORMAL_WIDTH;

  // Per-item data that rides alongside the square root and reciprocal units.
  typedef struct packed {
    logic [2:0][MANT_BITS-1:0] t;
    logic [2:0]                neg;
    logic                      deg;
  } side_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] s;
    logic [WORD_BITS-1:0] r;
  } sq_t;

  typedef struct packed {
    logic [LEN_BITS-1:0] rem;
    logic [LEN_BITS-1:0] low;
    logic [LEN_BITS-1:0] q;
    logic [LEN_BITS-1:0] len;
  } dv_t;

  // Two digit steps of the bitwise integer square root.
  function automatic sq_t sqrt_steps(sq_t x, int unsigned stage);
    sq_t                  y;
    logic [WORD_BITS-1:0] bit_v;
    logic [WORD_BITS-1:0] trial;
    y = x;
    for (int i = 0; i < 2; i++) begin
      bit_v = WORD_BITS'(1) << (62 - 4 * stage - 2 * i);
      trial = y.r + bit_v;
      if (y.s >= trial) begin
        y.s = y.s - trial;
        y.r = (y.r >> 1) + bit_v;
      end else begin
        y.r = y.r >> 1;
      end
    end
    return y;
  endfunction

  // Two quotient bits of the restoring division.
  function automatic dv_t div_steps(dv_t x);
    dv_t               y;
    logic [LEN_BITS:0] tr;
    y = x;
    for (int i = 0; i < 2; i++) begin
      tr    = {y.rem, y.low[LEN_BITS-1]};
      y.low = {y.low[LEN_BITS-2:0], 1'b0};
      if (tr >= {1'b0, y.len}) begin
        tr  = tr - {1'b0, y.len};
        y.q = {y.q[LEN_BITS-2:0], 1'b1};
      end else begin
        y.q = {y.q[LEN_BITS-2:0], 1'b0};
      end
      y.rem = tr[LEN_BITS-1:0];
    end
    return y;
  endfunction

  function automatic logic [BLEN_BITS-1:0] bit_len(logic [CROSS_BITS-1:0] x);
    logic [BLEN_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < CROSS_BITS; i++) begin
      if (x[i]) begin
        n = BLEN_BITS'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

// ----- rtl/tun_rsqrt.sv -----
// Pipelined rounded square root followed by a pipelined rounded reciprocal,
// giving floor((2^60 + len/2) / len). Depends on tun_pkg.
module tun_rsqrt (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic [tun_pkg::SUM_BITS-1:0]      s_i,
  input  tun_pkg::side_t                    side_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic [tun_pkg::LEN_BITS-1:0]      r_o,
  output tun_pkg::side_t                    side_o
);

  localparam int unsigned NST = tun_pkg::SQ_STAGES + 1 + tun_pkg::DV_STAGES;

  logic [NST-1:0]  v_q;
  logic [NST-1:0]  en;
  tun_pkg::side_t  side_q [NST];
  tun_pkg::sq_t    sq_q   [tun_pkg::SQ_STAGES];
  tun_pkg::dv_t    dv_q   [tun_pkg::DV_STAGES+1];

  assign en[NST-1] = !v_q[NST-1] || ready_i;

  for (genvar g = 0; g < NST - 1; g++) begin : g_en
    assign en[g] = !v_q[g] || en[g+1];
  end

  for (genvar g = 0; g < NST; g++) begin : g_ctl
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en[g]) begin
          v_q[g] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          side_q[g] <= side_i;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[g] <= 1'b0;
        end else if (en[g]) begin
          v_q[g] <= v_q[g-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          side_q[g] <= side_q[g-1];
        end
      end
    end
  end

  // Square root: two result bits per stage, starting from the top digit.
  for (genvar g = 0; g < tun_pkg::SQ_STAGES; g++) begin : g_sq
    if (g == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          sq_q[g] <= tun_pkg::sqrt_steps(
              tun_pkg::sq_t'{s: tun_pkg::WORD_BITS'(s_i), r: '0}, g);
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i) begin
        if (en[g]) begin
          sq_q[g] <= tun_pkg::sqrt_steps(sq_q[g-1], g);
        end
      end
    end
  end

  // Round the root to nearest and set up the dividend 2^60 + len/2.
  logic [tun_pkg::LEN_BITS-1:0] len;
  tun_pkg::sq_t                 sq_last;

  assign sq_last = sq_q[tun_pkg::SQ_STAGES-1];
  assign len = (sq_last.s > sq_last.r) ? tun_pkg::LEN_BITS'(sq_last.r + 1'b1)
                                       : tun_pkg::LEN_BITS'(sq_last.r);

  always_ff @(posedge clk_i) begin
    if (en[tun_pkg::SQ_STAGES]) begin
      dv_q[0].rem <= tun_pkg::LEN_BITS'(1) << (tun_pkg::RSQ_BITS - tun_pkg::LEN_BITS);
      dv_q[0].low <= {1'b0, len[tun_pkg::LEN_BITS-1:1]};
      dv_q[0].q   <= '0;
      dv_q[0].len <= len;
    end
  end

  for (genvar g = 0; g < tun_pkg::DV_STAGES; g++) begin : g_dv
    always_ff @(posedge clk_i) begin
      if (en[tun_pkg::SQ_STAGES+1+g]) begin
        dv_q[g+1] <= tun_pkg::div_steps(dv_q[g]);
      end
    end
  end

  assign ready_o = en[0];
  assign valid_o = v_q[NST-1];
  assign r_o     = dv_q[tun_pkg::DV_STAGES].q;
  assign side_o  = side_q[NST-1];

endmodule

// ----- rtl/triangle_unit_normal.sv -----
// Throughput one request per cycle while m_axis_tready is held high, through
// the 16-stage square root and the 16-stage reciprocal.
// Every stage holds under back pressure, so a stall loses nothing.
// Reset (rst_ni, asynchronous, active low) clears all valid bits.
// Top level of the triangle unit normal; depends on tun_pkg and tun_rsqrt.
module triangle_unit_normal (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, origin_x, origin_y, origin_z
  input  logic [tun_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // normal_x, normal_y, normal_z
  output logic [tun_pkg::OUT_DATA_BITS-1:0]     m_axis_tdata,
  // degenerate
  output logic                                  m_axis_tuser
);

  logic en1, en2, en3, en4, en5, en6, en7, en8, en9, en10;
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q;
  logic rs_ready, rs_valid;

  assign en10 = !v10_q || m_axis_tready;
  assign en9  = !v9_q || en10;
  assign en8  = !v8_q || rs_ready;
  assign en7  = !v7_q || en8;
  assign en6  = !v6_q || en7;
  assign en5  = !v5_q || en6;
  assign en4  = !v4_q || en5;
  assign en3  = !v3_q || en4;
  assign en2  = !v2_q || en3;
  assign en1  = !v1_q || en2;
  assign s_axis_tready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
    end else begin
      if (en1)  v1_q  <= s_axis_tvalid;
      if (en2)  v2_q  <= v1_q;
      if (en3)  v3_q  <= v2_q;
      if (en4)  v4_q  <= v3_q;
      if (en5)  v5_q  <= v4_q;
      if (en6)  v6_q  <= v5_q;
      if (en7)  v7_q  <= v6_q;
      if (en8)  v8_q  <= v7_q;
      if (en9)  v9_q  <= rs_valid;
      if (en10) v10_q <= v9_q;
    end
  end

  // Stage 1: edge vectors.
  logic signed [tun_pkg::COORD_BITS-1:0] crd [tun_pkg::NUM_COORDS];
  logic signed [tun_pkg::DIFF_BITS-1:0]  eu_q [3];
  logic signed [tun_pkg::DIFF_BITS-1:0]  ev_q [3];

  for (genvar i = 0; i < tun_pkg::NUM_COORDS; i++) begin : g_crd
    assign crd[i] = s_axis_tdata[i*tun_pkg::COORD_BITS +: tun_pkg::COORD_BITS];
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      for (int i = 0; i < 3; i++) begin
        eu_q[i] <= tun_pkg::DIFF_BITS'(crd[i])   - tun_pkg::DIFF_BITS'(crd[6+i]);
        ev_q[i] <= tun_pkg::DIFF_BITS'(crd[3+i]) - tun_pkg::DIFF_BITS'(crd[6+i]);
      end
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic signed [tun_pkg::PROD_BITS-1:0] prod_q [6];

  always_ff @(posedge clk_i) begin
    if (en2) begin
      prod_q[0] <= eu_q[1] * ev_q[2];
      prod_q[1] <= eu_q[2] * ev_q[1];
      prod_q[2] <= eu_q[2] * ev_q[0];
      prod_q[3] <= eu_q[0] * ev_q[2];
      prod_q[4] <= eu_q[0] * ev_q[1];
      prod_q[5] <= eu_q[1] * ev_q[0];
    end
  end

  // Stage 3: cross product.
  logic signed [tun_pkg::CROSS_BITS-1:0] cross_q [3];

  always_ff @(posedge clk_i) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        cross_q[i] <= tun_pkg::CROSS_BITS'(prod_q[2*i])
                    - tun_pkg::CROSS_BITS'(prod_q[2*i+1]);
      end
    end
  end

  // Stage 4: magnitudes and signs.
  logic [tun_pkg::CROSS_BITS-1:0] mag4_q [3];
  logic [2:0]                     neg4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        neg4_q[i] <= cross_q[i][tun_pkg::CROSS_BITS-1];
        mag4_q[i] <= cross_q[i][tun_pkg::CROSS_BITS-1] ? -cross_q[i] : cross_q[i];
      end
    end
  end

  // Stage 5: bit length of the largest magnitude.
  logic [tun_pkg::CROSS_BITS-1:0] mag5_q [3];
  logic [2:0]                     neg5_q;
  logic [tun_pkg::BLEN_BITS-1:0]  blen_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      mag5_q <= mag4_q;
      neg5_q <= neg4_q;
      blen_q <= tun_pkg::bit_len(mag4_q[0] | mag4_q[1] | mag4_q[2]);
    end
  end

  // Stage 6: align so the largest magnitude has exactly MANT_BITS bits.
  tun_pkg::side_t side6_q, side7_q, side8_q, side_rs, side9_q;
  logic [tun_pkg::CROSS_BITS+tun_pkg::MANT_BITS-1:0] aligned [3];

  for (genvar i = 0; i < 3; i++) begin : g_align
    assign aligned[i] = {mag5_q[i], {tun_pkg::MANT_BITS{1'b0}}} >> blen_q;
  end

  always_ff @(posedge clk_i) begin
    if (en6) begin
      for (int i = 0; i < 3; i++) begin
        side6_q.t[i] <= aligned[i][tun_pkg::MANT_BITS-1:0];
      end
      side6_q.neg <= neg5_q;
      side6_q.deg <= (blen_q == '0);
    end
  end

  // Stages 7 and 8: sum of squares.
  logic [tun_pkg::SQR_BITS-1:0] sqr_q [3];
  logic [tun_pkg::SUM_BITS-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en7) begin
      for (int i = 0; i < 3; i++) begin
        sqr_q[i] <= side6_q.t[i] * side6_q.t[i];
      end
      side7_q <= side6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en8) begin
      sum_q   <= tun_pkg::SUM_BITS'(sqr_q[0]) + tun_pkg::SUM_BITS'(sqr_q[1])
               + tun_pkg::SUM_BITS'(sqr_q[2]);
      side8_q <= side7_q;
    end
  end

  logic [tun_pkg::LEN_BITS-1:0] rsq;

  tun_rsqrt u_rsqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v8_q),
    .ready_o (rs_ready),
    .s_i     (sum_q),
    .side_i  (side8_q),
    .valid_o (rs_valid),
    .ready_i (en9),
    .r_o     (rsq),
    .side_o  (side_rs)
  );

  // Stage 9: scale each component by the reciprocal length.
  logic [tun_pkg::NPROD_BITS-1:0] nprod_q [3];

  always_ff @(posedge clk_i) begin
    if (en9) begin
      for (int i = 0; i < 3; i++) begin
        nprod_q[i] <= side_rs.t[i] * rsq;
      end
      side9_q <= side_rs;
    end
  end

  // Stage 10: round half up, clamp to 1.0, apply sign; a degenerate result is zero.
  logic [tun_pkg::NPROD_BITS:0]     rsum [3];
  logic [tun_pkg::NRM_BITS-1:0]     nrm  [3];
  logic [tun_pkg::NORMAL_WIDTH-1:0] comp [3];
  logic [tun_pkg::OUT_DATA_BITS-1:0] out_data_q;
  logic                              out_deg_q;

  for (genvar i = 0; i < 3; i++) begin : g_round
    assign rsum[i] = (tun_pkg::NPROD_BITS+1)'(nprod_q[i])
                   + ((tun_pkg::NPROD_BITS+1)'(1) << (tun_pkg::RND_SHIFT - 1));
    always_comb begin
      nrm[i] = rsum[i][tun_pkg::NPROD_BITS:tun_pkg::RND_SHIFT];
      if (nrm[i] > (tun_pkg::NRM_BITS'(1) << tun_pkg::OUT_FRAC_BITS)) begin
        nrm[i] = tun_pkg::NRM_BITS'(1) << tun_pkg::OUT_FRAC_BITS;
      end
      if (side9_q.deg) begin
        comp[i] = '0;
      end else if (side9_q.neg[i]) begin
        comp[i] = -tun_pkg::NORMAL_WIDTH'(nrm[i]);
      end else begin
        comp[i] = tun_pkg::NORMAL_WIDTH'(nrm[i]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en10) begin
      out_data_q <= {comp[2], comp[1], comp[0]};
      out_deg_q  <= side9_q.deg;
    end
  end

  assign m_axis_tvalid = v10_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_deg_q;

endmodule

// ----- verif/tun_checker.sv -----
// Checker for the triangle unit normal: watches both stream channels, predicts
// each normal from the accepted points and compares it with the result.
// Depends on tun_pkg.
module tun_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  input  logic                              s_axis_tready,
  input  logic [tun_pkg::IN_DATA_BITS-1:0]  s_axis_tdata,
  input  logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  input  logic [tun_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input  logic                              m_axis_tuser,
  output int                                fail_count_o,
  output int                                pending_o
);

  typedef struct packed {
    logic       deg;
    logic [15:0] nz;
    logic [15:0] ny;
    logic [15:0] nx;
  } normal_t;

  normal_t normal_q[$];

  function automatic logic [63:0] isqrt_near(logic [63:0] s);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return (s > r) ? r + 1 : r;
  endfunction

  function automatic normal_t predict_normal(logic [tun_pkg::IN_DATA_BITS-1:0] d);
    logic signed [tun_pkg::COORD_BITS-1:0] p[9];
    logic signed [63:0]  u[3];
    logic signed [63:0]  v[3];
    logic signed [127:0] c[3];
    logic [127:0]        m[3];
    logic [63:0]         t[3];
    logic [63:0]         s;
    logic [63:0]         len;
    logic [63:0]         rs;
    logic [127:0]        n;
    logic [15:0]         comp[3];
    int                  b;
    normal_t             res;
    for (int i = 0; i < 9; i++) begin
      p[i] = d[i*tun_pkg::COORD_BITS +: tun_pkg::COORD_BITS];
    end
    for (int i = 0; i < 3; i++) begin
      u[i] = 64'(p[i]) - 64'(p[6+i]);
      v[i] = 64'(p[3+i]) - 64'(p[6+i]);
    end
    c[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
    c[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
    c[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
    b = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = c[i] < 0 ? 128'(-c[i]) : 128'(c[i]);
      for (int k = 0; k < 128; k++) if (m[i][k] && k + 1 > b) b = k + 1;
    end
    res = '0;
    if (b == 0) begin
      res.deg = 1'b1;
      return res;
    end
    s = 0;
    for (int i = 0; i < 3; i++) begin
      t[i] = (b > tun_pkg::MANT_BITS) ? 64'(m[i] >> (b - tun_pkg::MANT_BITS))
                                      : 64'(m[i] << (tun_pkg::MANT_BITS - b));
      s = s + t[i] * t[i];
    end
    len = isqrt_near(s);
    rs = ((64'd1 << tun_pkg::RSQ_BITS) + (len >> 1)) / len;
    for (int i = 0; i < 3; i++) begin
      n = (128'(t[i]) * 128'(rs) + (128'd1 << (tun_pkg::RND_SHIFT - 1)))
          >> tun_pkg::RND_SHIFT;
      if (n > (128'd1 << tun_pkg::OUT_FRAC_BITS)) n = 128'd1 << tun_pkg::OUT_FRAC_BITS;
      comp[i] = c[i] < 0 ? 16'(-n) : 16'(n);
    end
    res.nx = comp[0];
    res.ny = comp[1];
    res.nz = comp[2];
    return res;
  endfunction

  assign pending_o = normal_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) normal_q.push_back(predict_normal(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (normal_q.size() == 0) begin
          $error("unexpected normal result %h", m_axis_tdata);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = normal_q.pop_front();
          if (want.nx !== m_axis_tdata[15:0] || want.ny !== m_axis_tdata[31:16] ||
              want.nz !== m_axis_tdata[47:32] || want.deg !== m_axis_tuser)
            fail_count_o <= fail_count_o + 1;
          if (want.nx !== m_axis_tdata[15:0])
            $error("normal_x expected %h got %h", want.nx, m_axis_tdata[15:0]);
          if (want.ny !== m_axis_tdata[31:16])
            $error("normal_y expected %h got %h", want.ny, m_axis_tdata[31:16]);
          if (want.nz !== m_axis_tdata[47:32])
            $error("normal_z expected %h got %h", want.nz, m_axis_tdata[47:32]);
          if (want.deg !== m_axis_tuser)
            $error("degenerate expected %b got %b", want.deg, m_axis_tuser);
        end
      end
    end
  end
endmodule

// ----- verif/tb_top.sv -----
// Stimulus and verdict for the triangle unit normal testbench.
// Depends on tun_pkg, triangle_unit_normal and tun_checker.
module tb_top;

  localparam logic [23:0] MAX_C = 24'h7fffff;
  localparam logic [23:0] MIN_C = 24'h800000;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [tun_pkg::IN_DATA_BITS-1:0]  s_axis_tdata;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [tun_pkg::OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                              m_axis_tuser;
  int                                fail_count;
  int                                pending;
  int                                send_idle_pct;
  int                                stall_pct;
  int                                cycles;

  triangle_unit_normal u_top (.*);

  tun_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stalls at random; the rate changes with the phase.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cycles <= 0;
    end else begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [23:0] rand_coord(int mode);
    case (mode)
      0: return 24'($urandom);
      1: return 24'($signed($urandom_range(512)) - 256);
      default: return $urandom_range(1) ? MAX_C : MIN_C;
    endcase
  endfunction

  task automatic send_points(input logic [tun_pkg::IN_DATA_BITS-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_tri(input logic [23:0] c[9]);
    logic [tun_pkg::IN_DATA_BITS-1:0] d;
    for (int i = 0; i < 9; i++) d[i*24 +: 24] = c[i];
    send_points(d);
  endtask

  initial begin
    logic [23:0] c[9];
    int          mode;
    rst_ni = 0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    send_idle_pct = 0;
    stall_pct = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    // Directed: all zero (degenerate), coincident points, collinear points,
    // axis-aligned triangles, extreme coordinate values, small triangles.
    c = '{default: 24'd0};
    send_tri(c);
    c = '{24'd256, 24'd512, 24'd768, 24'd256, 24'd512, 24'd768, 0, 0, 0};
    send_tri(c);
    c = '{24'd256, 24'd256, 24'd256, 24'd512, 24'd512, 24'd512, 0, 0, 0};
    send_tri(c);
    c = '{24'd256, 0, 0, 0, 24'd256, 0, 0, 0, 0};
    send_tri(c);
    c = '{0, 24'd256, 0, 0, 0, 24'd256, 0, 0, 0};
    send_tri(c);
    c = '{0, 0, 24'd256, 24'd256, 0, 0, 0, 0, 0};
    send_tri(c);
    c = '{MAX_C, MIN_C, MAX_C, MIN_C, MAX_C, 0, MIN_C, MIN_C, MAX_C};
    send_tri(c);
    c = '{MAX_C, 0, 0, 0, MAX_C, 0, MIN_C, MIN_C, MIN_C};
    send_tri(c);
    c = '{MIN_C, 0, 0, 0, MIN_C, 0, MAX_C, MAX_C, MAX_C};
    send_tri(c);
    c = '{MAX_C, MAX_C, MAX_C, MIN_C, MIN_C, MIN_C, 0, 0, 0};
    send_tri(c);
    c = '{24'd1, 0, 0, 0, 24'd1, 0, 0, 0, 0};
    send_tri(c);
    c = '{24'd1, 24'd1, 0, 24'hffffff, 24'd1, 24'd3, 0, 0, 24'hffffff};
    send_tri(c);
    for (int k = 0; k < 1000; k++) begin
      case ((k / 125) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 16; stall_pct = 16; end
      endcase
      mode = $urandom_range(9);
      for (int i = 0; i < 9; i++) c[i] = rand_coord(mode < 6 ? 0 : (mode < 9 ? 1 : 2));
      // Some collinear or repeated-point cases to hit the degenerate path.
      if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) c[3+i] = c[i];
      if ($urandom_range(19) == 0) for (int i = 0; i < 3; i++) c[3+i] = c[6+i];
      send_tri(c);
    end
    s_axis_tvalid <= 1'b0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
